### src/glf_pkg.sv
// ----------------------------------------------------------------------------
// glf_pkg: shared types and constants of the glob line filter
// Pattern sizes, character codes, register indexes and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package glf_pkg;

    localparam int PATTERN_LEN = 32;
    localparam int MAX_CHARS   = 32;
    localparam int EFF_MAX     = (PATTERN_LEN < MAX_CHARS) ? PATTERN_LEN : MAX_CHARS;
    localparam int NUM_POS     = EFF_MAX + 1;
    localparam int CHAR_REGS   = 4;
    localparam int LEN_W       = 6;
    localparam int LINE_LEN_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [7:0] CHAR_STAR     = 8'h2A;
    localparam logic [7:0] CHAR_QUESTION = 8'h3F;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_ENABLE    = 3'd0,
        CFG_PATTERN_LENGTH   = 3'd1,
        CFG_CHARS_LO         = 3'd2,
        CFG_CHARS_MID_LO     = 3'd3,
        CFG_CHARS_MID_HI     = 3'd4,
        CFG_CHARS_HI         = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic step;   // non-newline byte taken
        logic clear;  // newline taken
    } cell_ctrl_t;

    typedef struct packed {
        logic                  line_matched;
        logic [LINE_LEN_W-1:0] line_length;
    } result_t;

endpackage

`default_nettype wire

### src/glf_ifs.sv
// ----------------------------------------------------------------------------
// glf interfaces: handshake channels of the glob line filter
// Text input, result output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface glf_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);
endinterface

interface glf_result_if;
    logic                           valid;
    logic                           ready;
    logic                           line_matched;
    logic [glf_pkg::LINE_LEN_W-1:0] line_length;

    modport source (output valid, output line_matched, output line_length, input ready);
    modport sink   (input valid, input line_matched, input line_length, output ready);
endinterface

interface glf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [glf_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [glf_pkg::CFG_DATA_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### src/glob_line_filter_unit.sv
// ----------------------------------------------------------------------------
// glob_line_filter_unit: streaming glob line filter
// Splits a byte stream into lines and matches each line against a glob
// pattern with a row of NFA position cells.
// ----------------------------------------------------------------------------
//  channel     dir  word
//  text_in     in   text_byte[7:0]
//  result_out  out  line_matched, line_length[15:0]
//  cfg         in   reg_index[2:0], wdata[63:0]
//
//  one byte per cycle unless stalled; an enabled newline word puts its result
//  on result_out in the following cycle, or later when a stalled result still holds it
//  the per-byte step is one pass of the star closure carry chain plus the
//  compare in each cell
//  text_in stalls only when both output register and skid stage are full
//  cfg is always ready; reset leaves position 0 active and a zero count
// ----------------------------------------------------------------------------
`default_nettype none

module glob_line_filter_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    glf_text_if.sink      text_in,
    glf_result_if.source  result_out,
    glf_cfg_if.sink       cfg
);

    logic                              filter_enable_reg;
    logic [glf_pkg::LEN_W-1:0]         pattern_length_reg;
    logic [glf_pkg::CFG_DATA_W-1:0]    pattern_chars_reg [glf_pkg::CHAR_REGS];
    logic [glf_pkg::LINE_LEN_W-1:0]    line_count_reg;
    logic [glf_pkg::LINE_LEN_W-1:0]    line_count_next;

    logic                              accept;
    logic                              is_newline;
    logic                              space;
    logic                              res_valid;
    glf_pkg::result_t                  res;
    glf_pkg::cell_ctrl_t               ctrl;
    logic [glf_pkg::LEN_W-1:0]         eff_len;
    logic [glf_pkg::NUM_POS-1:0]       active;
    logic [glf_pkg::NUM_POS-1:0]       closed;
    logic [glf_pkg::NUM_POS-1:0]       star_mask;
    logic [glf_pkg::NUM_POS-1:0]       in_use;
    logic [glf_pkg::NUM_POS:0]         adv;
    logic [7:0]                        pat_char [glf_pkg::NUM_POS];

    assign cfg.ready     = 1'b1;
    assign text_in.ready = space;
    assign accept        = text_in.valid & space;
    assign is_newline    = (text_in.text_byte == glf_pkg::CHAR_NEWLINE);
    assign ctrl.step     = accept & ~is_newline;
    assign ctrl.clear    = accept & is_newline;

    assign eff_len = (pattern_length_reg > glf_pkg::LEN_W'(glf_pkg::EFF_MAX))
                   ? glf_pkg::LEN_W'(glf_pkg::EFF_MAX) : pattern_length_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg  <= 1'b0;
            pattern_length_reg <= '0;
            for (int k = 0; k < glf_pkg::CHAR_REGS; k++)
            begin
                pattern_chars_reg[k] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            unique case (cfg.reg_index)
                glf_pkg::CFG_FILTER_ENABLE:  filter_enable_reg     <= cfg.wdata[0];
                glf_pkg::CFG_PATTERN_LENGTH: pattern_length_reg    <= cfg.wdata[glf_pkg::LEN_W-1:0];
                glf_pkg::CFG_CHARS_LO:       pattern_chars_reg[0]  <= cfg.wdata;
                glf_pkg::CFG_CHARS_MID_LO:   pattern_chars_reg[1]  <= cfg.wdata;
                glf_pkg::CFG_CHARS_MID_HI:   pattern_chars_reg[2]  <= cfg.wdata;
                glf_pkg::CFG_CHARS_HI:       pattern_chars_reg[3]  <= cfg.wdata;
                default:
                begin
                end
            endcase
        end
    end

    // position cells
    assign adv[0] = 1'b0;

    for (genvar i = 0; i < glf_pkg::NUM_POS; i++)
    begin : g_pos
        if (i < glf_pkg::EFF_MAX)
        begin : g_char
            assign pat_char[i] = pattern_chars_reg[i / 8][(i % 8) * 8 +: 8];
        end
        else
        begin : g_end
            assign pat_char[i] = 8'h00;
        end

        assign in_use[i]    = (glf_pkg::LEN_W'(i) < eff_len);
        assign star_mask[i] = in_use[i] & (pat_char[i] == glf_pkg::CHAR_STAR);

        glf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .home      ((i == 0) ? 1'b1 : 1'b0),
            .in_use    (in_use[i]),
            .pat_char  (pat_char[i]),
            .text_byte (text_in.text_byte),
            .closed    (closed[i]),
            .adv_in    (adv[i]),
            .adv_out   (adv[i+1]),
            .active    (active[i])
        );
    end

    glf_closure u_closure (
        .raw       (active),
        .star_mask (star_mask),
        .eff_len   (eff_len),
        .closed    (closed)
    );

    // saturating line length
    always_comb
    begin
        line_count_next = line_count_reg;
        if (ctrl.clear)
        begin
            line_count_next = '0;
        end
        else if (ctrl.step && !(&line_count_reg))
        begin
            line_count_next = line_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= '0;
        end
        else
        begin
            line_count_reg <= line_count_next;
        end
    end

    assign res_valid        = ctrl.clear & filter_enable_reg;
    assign res.line_matched = closed[eff_len];
    assign res.line_length  = line_count_reg;

    glf_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .space      (space),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

### src/glf_cell.sv
// ----------------------------------------------------------------------------
// glf_cell: one pattern position of the NFA
// Holds the active bit of its position and passes an advance to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module glf_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire glf_pkg::cell_ctrl_t ctrl,
    input  wire logic                home,      // value after reset and newline
    input  wire logic                in_use,
    input  wire logic [7:0]          pat_char,
    input  wire logic [7:0]          text_byte,
    input  wire logic                closed,    // this position after star closure
    input  wire logic                adv_in,
    output logic                     adv_out,
    output logic                     active
);

    logic flip_reg;
    logic flip_next;
    logic live;
    logic is_star;
    logic hit;

    // stored relative to home so reset is a plain clear
    assign active  = flip_reg ^ home;
    assign live    = closed & in_use;
    assign is_star = (pat_char == glf_pkg::CHAR_STAR);
    assign hit     = (pat_char == glf_pkg::CHAR_QUESTION) | (pat_char == text_byte);
    assign adv_out = live & ~is_star & hit;

    always_comb
    begin
        flip_next = flip_reg;
        if (ctrl.clear)
        begin
            flip_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            flip_next = ((live & is_star) | adv_in) ^ home;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_reg <= 1'b0;
        end
        else
        begin
            flip_reg <= flip_next;
        end
    end

endmodule

`default_nettype wire

### src/glf_closure.sv
// ----------------------------------------------------------------------------
// glf_closure: star closure of the active positions
// Fills each active run forward across star positions with one carry chain.
// ----------------------------------------------------------------------------
`default_nettype none

module glf_closure (
    input  wire logic [glf_pkg::NUM_POS-1:0] raw,
    input  wire logic [glf_pkg::NUM_POS-1:0] star_mask,
    input  wire logic [glf_pkg::LEN_W-1:0]   eff_len,
    output logic      [glf_pkg::NUM_POS-1:0] closed
);

    logic [glf_pkg::NUM_POS-1:0] keep;
    logic [glf_pkg::NUM_POS-1:0] gen;
    logic [glf_pkg::NUM_POS-1:0] prop;
    logic [glf_pkg::NUM_POS-1:0] run;
    logic [glf_pkg::NUM_POS:0]   sum;

    for (genvar j = 0; j < glf_pkg::NUM_POS; j++)
    begin : g_keep
        assign keep[j] = (glf_pkg::LEN_W'(j) <= eff_len);
    end

    assign gen  = raw & keep;
    // a star at position j lets position j+1 inherit j
    assign prop = {star_mask[glf_pkg::NUM_POS-2:0], 1'b0};
    assign run  = prop | gen;
    // carry from each active bit runs through the following run bits
    assign sum    = {1'b0, run} + {1'b0, gen};
    assign closed = (run & (sum[glf_pkg::NUM_POS-1:0] ^ run)) | gen;

endmodule

`default_nettype wire

### src/glf_out_buf.sv
// ----------------------------------------------------------------------------
// glf_out_buf: result output register with skid stage
// Keeps the input side running while a result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module glf_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_valid,
    input  wire glf_pkg::result_t res,
    output logic                  space,
    glf_result_if.source          result_out
);

    logic             out_valid_reg;
    logic             out_valid_next;
    glf_pkg::result_t out_data_reg;
    glf_pkg::result_t out_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    glf_pkg::result_t skid_data_reg;
    glf_pkg::result_t skid_data_next;
    logic             load_out;

    assign space                   = ~skid_valid_reg;
    assign load_out                = ~out_valid_reg | result_out.ready;
    assign result_out.valid        = out_valid_reg;
    assign result_out.line_matched = out_data_reg.line_matched;
    assign result_out.line_length  = out_data_reg.line_length;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (load_out)
        begin
            out_valid_next  = skid_valid_reg | res_valid;
            out_data_next   = skid_valid_reg ? skid_data_reg : res;
            skid_valid_next = skid_valid_reg & res_valid;
            if (res_valid)
            begin
                skid_data_next = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

### src/glf_checker.sv
// ----------------------------------------------------------------------------
// glf_checker: port-level checks of the glob line filter
// Watches the handshakes and the result timing at the top level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module glf_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [7:0]                     in_byte,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic                           out_matched,
    input  wire logic [glf_pkg::LINE_LEN_W-1:0] out_length,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [glf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [glf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic enable_reg;
    logic nl_taken;

    assign nl_taken = in_valid & in_ready & (in_byte == glf_pkg::CHAR_NEWLINE);

    // shadow of the enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready && cfg_index == glf_pkg::CFG_FILTER_ENABLE)
        begin
            enable_reg <= cfg_wdata[0];
        end
    end

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_matched) && $stable(out_length))
        else $error("result word changed while stalled");

    // a result starts only from a newline word taken the cycle before
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(nl_taken))
        else $error("result without newline");

    // an enabled newline into an empty output shows next cycle
    a_out_prompt: assert property (@(posedge clk) disable iff (!rst_n)
        nl_taken && enable_reg && !out_valid |=> out_valid)
        else $error("enabled newline gave no result");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with empty output");

endmodule

bind glob_line_filter_unit glf_checker u_glf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (text_in.valid),
    .in_ready    (text_in.ready),
    .in_byte     (text_in.text_byte),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .out_matched (result_out.line_matched),
    .out_length  (result_out.line_length),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready),
    .cfg_index   (cfg.reg_index),
    .cfg_wdata   (cfg.wdata)
);

`default_nettype wire
